[design/toti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toti_pkg
// shared types and constants for the two-opt tour improver
// ----------------------------------------------------------------------------
package toti_pkg;

  localparam logic [1:0] KIND_DIST  = 2'd0;
  localparam logic [1:0] KIND_TOUR  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic CFG_CITY_COUNT = 1'b0;
  localparam logic CFG_MIN_GAIN   = 1'b1;

  localparam logic [15:0] MOVE_SAT = 16'hFFFF;

  // distance read selector
  typedef enum logic [1:0] {
    DSEL_AB = 2'd0,
    DSEL_CD = 2'd1,
    DSEL_AC = 2'd2,
    DSEL_BD = 2'd3
  } dsel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_DAB,
    ST_DCD,
    ST_DAC,
    ST_DBD,
    ST_WAIT,
    ST_CMP,
    ST_FLIP_RD,
    ST_FLIP_WAIT,
    ST_FLIP_WR,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SHOW,
    ST_OUT_SEND
  } state_t;

  typedef struct packed {
    logic       init;       // start of a run: clear moves, i=0, k=1
    logic       sweep_init; // start of a new sweep
    logic [2:0] tsel;       // tour read selector: 0 i,1 i+1,2 k,3 k+1,4 lo,5 hi,6 out
    logic [2:0] tcap;       // capture tour data into a,b,c,d,lo,hi (binary code, index+1)
    logic       drd;        // issue distance read
    dsel_t      dsel;
    logic       dacc;       // accumulate returning distance
    dsel_t      asel;       // which pair the returning distance belongs to
    logic       flip_setup; // lo=i+1, hi=k, count move
    logic       flip_wr;    // write swap, step lo/hi
    logic       step_k;     // advance k/i
    logic       out_init;
    logic       out_load;   // latch output item
    logic       out_step;
  } cmd_t;

  typedef struct packed {
    logic better;
    logic flip_done;
    logic last_pair;
    logic moved;
    logic sat;
    logic out_last;
  } sts_t;

endpackage

[design/toti_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toti_datapath
// distance memory, tour memory, pair compare and reversal datapath
// ----------------------------------------------------------------------------
module toti_datapath import toti_pkg::*; #(
  parameter int MAX_CITIES = 32,
  parameter int DIST_WIDTH = 24,
  parameter int IW = $clog2(MAX_CITIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  dist_we,
  input  logic [4:0]            dist_from,
  input  logic [4:0]            dist_to,
  input  logic [DIST_WIDTH-1:0] dist_val,
  input  logic                  tour_we,
  input  logic [4:0]            tour_pos,
  input  logic [4:0]            tour_city,
  input  logic [5:0]            n,
  input  logic [23:0]           min_gain,
  output logic [4:0]            o_pos,
  output logic [4:0]            o_city,
  output logic                  o_last,
  output logic [15:0]           o_moves
);

  localparam int GW = (DIST_WIDTH > 24) ? DIST_WIDTH : 24;
  localparam int SW = GW + 2;
  localparam int AW = $clog2(MAX_CITIES * MAX_CITIES);

  logic [DIST_WIDTH-1:0] dmem [MAX_CITIES*MAX_CITIES];
  logic [IW-1:0]         tmem [MAX_CITIES];
  logic [DIST_WIDTH-1:0] drd;
  logic [IW-1:0]         trd;

  logic [5:0]  i, k, lo, hi, op;
  logic [IW-1:0] ca, cb, cc, cd, tlo, thi;
  logic [SW-1:0] cur, alt;
  logic [15:0] moves;
  logic        moved;

  logic [5:0]  k1, tra;
  logic [IW-1:0] fr, to;
  logic        in_rng_d, in_rng_t;

  assign k1 = (k + 6'd1 == n) ? 6'd0 : k + 6'd1;

  always_comb begin
    unique case (cmd.tsel)
      3'd0:    tra = i;
      3'd1:    tra = i + 6'd1;
      3'd2:    tra = k;
      3'd3:    tra = k1;
      3'd4:    tra = lo;
      3'd5:    tra = hi;
      default: tra = op;
    endcase
    unique case (cmd.dsel)
      DSEL_AB: begin fr = ca; to = cb; end
      DSEL_CD: begin fr = cc; to = cd; end
      DSEL_AC: begin fr = ca; to = cc; end
      default: begin fr = cb; to = cd; end
    endcase
  end

  assign in_rng_d = (int'(dist_from) < MAX_CITIES) && (int'(dist_to) < MAX_CITIES);
  assign in_rng_t = (int'(tour_pos) < MAX_CITIES) && (int'(tour_city) < MAX_CITIES);

  // distance memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (dist_we && in_rng_d) begin
      dmem[AW'(int'(dist_from) * MAX_CITIES + int'(dist_to))] <= dist_val;
    end
    drd <= dmem[AW'(int'(fr) * MAX_CITIES + int'(to))];
  end

  // tour memory
  always_ff @(posedge clk) begin
    if (tour_we && in_rng_t) begin
      tmem[IW'(tour_pos)] <= IW'(tour_city);
    end else if (cmd.flip_wr) begin
      tmem[IW'(lo)] <= thi;
      tmem[IW'(hi)] <= tlo;
    end
    trd <= tmem[IW'(tra)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moves <= '0;
      moved <= 1'b0;
      i <= '0;
      k <= 6'd1;
      op <= '0;
    end else begin
      if (cmd.init) moves <= '0;
      if (cmd.init || cmd.sweep_init) begin
        i <= '0;
        k <= 6'd1;
        moved <= 1'b0;
      end
      if (cmd.flip_setup) begin
        moves <= moves + 16'd1;
        moved <= 1'b1;
      end
      if (cmd.step_k) begin
        if (k + 6'd1 >= n) begin
          i <= i + 6'd1;
          k <= i + 6'd2;
        end else begin
          k <= k + 6'd1;
        end
      end
      if (cmd.out_init) op <= '0;
      else if (cmd.out_step) op <= op + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.tcap)
      3'd1: ca <= trd;
      3'd2: cb <= trd;
      3'd3: cc <= trd;
      3'd4: cd <= trd;
      3'd5: tlo <= trd;
      3'd6: thi <= trd;
      default: ;
    endcase
    if (cmd.flip_setup) begin
      lo <= i + 6'd1;
      hi <= k;
    end
    if (cmd.flip_wr) begin
      lo <= lo + 6'd1;
      hi <= hi - 6'd1;
    end
    if (cmd.dacc) begin
      unique case (cmd.asel)
        DSEL_AB: cur <= SW'(drd);
        DSEL_CD: cur <= cur + SW'(drd);
        DSEL_AC: alt <= SW'(drd) + SW'(min_gain);
        default: alt <= alt + SW'(drd);
      endcase
    end
    if (cmd.out_load) begin
      o_pos   <= 5'(op);
      o_city  <= 5'(trd);
      o_last  <= (op + 6'd1 == n);
      o_moves <= moves;
    end
  end

  assign sts.better    = alt < cur;
  assign sts.flip_done = !(lo < hi);
  assign sts.last_pair = (i + 6'd2 >= n) && (k + 6'd1 >= n);
  assign sts.moved     = moved;
  assign sts.sat       = moves == MOVE_SAT;
  assign sts.out_last  = op + 6'd1 == n;

endmodule

[design/toti_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toti_control
// sequencer for the search, reversal and emit phases
// ----------------------------------------------------------------------------
module toti_control import toti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  state_t state, state_next;
  logic   dacc_q;
  dsel_t  dsel_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      dacc_q <= 1'b0;
      dsel_q <= DSEL_AB;
    end else begin
      state  <= state_next;
      dacc_q <= cmd.drd;
      dsel_q <= cmd.dsel;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.tsel = 3'd6;
    cmd.dsel = dsel_q;
    cmd.dacc = dacc_q;
    cmd.asel = dsel_q;
    state_next = state;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.init = 1'b1;
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: begin cmd.tsel = 3'd0; state_next = ST_RD_B; end
      ST_RD_B: begin cmd.tsel = 3'd1; cmd.tcap = 3'd1; state_next = ST_RD_C; end
      ST_RD_C: begin cmd.tsel = 3'd2; cmd.tcap = 3'd2; state_next = ST_RD_D; end
      ST_RD_D: begin cmd.tsel = 3'd3; cmd.tcap = 3'd3; state_next = ST_DAB; end
      ST_DAB: begin
        cmd.tcap = 3'd4;
        cmd.drd = 1'b1;
        cmd.dsel = DSEL_AB;
        state_next = ST_DCD;
      end
      ST_DCD: begin cmd.drd = 1'b1; cmd.dsel = DSEL_CD; state_next = ST_DAC; end
      ST_DAC: begin cmd.drd = 1'b1; cmd.dsel = DSEL_AC; state_next = ST_DBD; end
      ST_DBD: begin cmd.drd = 1'b1; cmd.dsel = DSEL_BD; state_next = ST_WAIT; end
      ST_WAIT: begin state_next = ST_CMP; end
      ST_CMP: begin
        if (sts.better) begin
          cmd.flip_setup = 1'b1;
          state_next = ST_FLIP_RD;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_FLIP_RD: begin
        if (sts.flip_done) begin
          if (sts.sat) begin
            cmd.out_init = 1'b1;
            state_next = ST_OUT_RD;
          end else begin
            state_next = ST_NEXT;
          end
        end else begin
          cmd.tsel = 3'd4;
          state_next = ST_FLIP_WAIT;
        end
      end
      ST_FLIP_WAIT: begin cmd.tsel = 3'd5; cmd.tcap = 3'd5; state_next = ST_FLIP_WR; end
      ST_FLIP_WR: begin cmd.tcap = 3'd6; state_next = ST_OUT_WAIT; end
      ST_NEXT: begin
        if (sts.last_pair) begin
          if (sts.moved) begin
            cmd.sweep_init = 1'b1;
            state_next = ST_RD_A;
          end else begin
            cmd.out_init = 1'b1;
            state_next = ST_OUT_RD;
          end
        end else begin
          cmd.step_k = 1'b1;
          state_next = ST_RD_A;
        end
      end
      ST_OUT_RD: begin
        // emit phase, op pointer already set
        cmd.tsel = 3'd6;
        state_next = ST_OUT_SHOW;
      end
      ST_OUT_WAIT: begin
        // swap write cycle of the reversal
        cmd.flip_wr = 1'b1;
        state_next = ST_FLIP_RD;
      end
      ST_OUT_SHOW: begin
        cmd.out_load = 1'b1;
        state_next = ST_OUT_SEND;
      end
      ST_OUT_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_last) state_next = ST_IDLE;
          else begin
            cmd.out_step = 1'b1;
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/two_opt_tour_improver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_opt_tour_improver
// first-improvement 2-opt search over a loaded distance table and tour
// ----------------------------------------------------------------------------
// channel   dir  tdata / tuser
// s_axis    in   tdata {city,position,distance,to_city,from_city}, tuser kind
// m_axis    out  tdata {move_count,out_city,out_position}, tlast is_last
// cfg       in   index, data
//
// loads are written straight into the memories and are accepted while the
// block is idle; a start reads four tour entries and four distances for each
// pair, swaps tour entries pairwise through the tour memory to reverse a
// better segment, then emits the tour one position at a time
// synchronous reset clears the sequencer, move count, sweep and output indices and config registers
// memories come up undefined and need no clearing pass
// a stalled output holds the sequencer in its emit state
// ----------------------------------------------------------------------------
module two_opt_tour_improver import toti_pkg::*; #(
  parameter int MAX_CITIES = 32,
  parameter int DIST_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from_city[4:0], to_city[9:5], distance[33:10], position[38:34], city[43:39]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_position[4:0], out_city[9:5], move_count[25:10]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic busy, acc;
  logic [5:0]  city_count, n;
  logic [23:0] min_gain;
  logic [4:0]  o_pos, o_city;
  logic        o_last;
  logic [15:0] o_moves;
  logic [1:0]  kind;

  assign kind = s_axis_tuser;
  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= 6'd32;
      min_gain   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CITY_COUNT) city_count <= cfg_data[5:0];
      else min_gain <= cfg_data;
    end
  end

  // clamp to 3..min(MAX_CITIES,32)
  localparam int LIM = (MAX_CITIES < 32) ? MAX_CITIES : 32;
  assign n = (city_count < 6'd3) ? 6'd3 : (city_count > 6'(LIM)) ? 6'(LIM) : city_count;

  toti_control u_ctrl (
    .clk, .rst,
    .start     (acc && kind == KIND_START),
    .out_ready (m_axis_tready),
    .sts, .cmd, .busy,
    .out_valid (m_axis_tvalid)
  );

  toti_datapath #(.MAX_CITIES(MAX_CITIES), .DIST_WIDTH(DIST_WIDTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .dist_we   (acc && kind == KIND_DIST),
    .dist_from (s_axis_tdata[4:0]),
    .dist_to   (s_axis_tdata[9:5]),
    .dist_val  (DIST_WIDTH'(s_axis_tdata[33:10])),
    .tour_we   (acc && kind == KIND_TOUR),
    .tour_pos  (s_axis_tdata[38:34]),
    .tour_city (s_axis_tdata[43:39]),
    .n, .min_gain, .o_pos, .o_city, .o_last, .o_moves
  );

  assign m_axis_tdata = {6'd0, o_moves, o_city, o_pos};
  assign m_axis_tlast = o_last;

  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> busy) else $error("output request while idle");
  a_tready: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken during search");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (acc && kind == KIND_START) |=> busy) else $error("start lost");

endmodule
